FILE: rtl/core/fqvr_pkg.sv
// Package with the shared constants and types of the value-removal FIFO queue.
`default_nettype none

package fqvr_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ValueWidth    = 32;
   localparam int ReqWidth      = 3;
   localparam int PosWidth      = 5;
   localparam int StatWidth     = 2;
   localparam int CountWidth    = 5;

   localparam logic [ReqWidth-1:0] REQ_PUSH   = 3'd0;
   localparam logic [ReqWidth-1:0] REQ_POP    = 3'd1;
   localparam logic [ReqWidth-1:0] REQ_READ   = 3'd2;
   localparam logic [ReqWidth-1:0] REQ_REMOVE = 3'd3;
   localparam logic [ReqWidth-1:0] REQ_CLEAR  = 3'd4;

   localparam logic [StatWidth-1:0] STAT_OK     = 2'd0;
   localparam logic [StatWidth-1:0] STAT_EMPTY  = 2'd1;
   localparam logic [StatWidth-1:0] STAT_FULL   = 2'd2;
   localparam logic [StatWidth-1:0] STAT_BADPOS = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_READ_WAIT,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/fifo_queue_with_value_removal.sv
// Top level of the bounded FIFO queue with read at position and removal by value.
// Push, clear, unused codes, empty-queue pops and removes, last-entry pops and bad reads respond
// in the cycle after acceptance. Other pops and in-range reads answer from the wait state after the
// registered memory read. Remove by value reads one entry each cycle and writes kept entries back.
// Results are never stalled. Synchronous reset empties the queue; memory contents are not cleared.
`default_nettype none

module fifo_queue_with_value_removal #(
   parameter int DEPTH = fqvr_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic        [fqvr_pkg::ReqWidth-1:0]   req_type,
   input  wire logic signed [fqvr_pkg::ValueWidth-1:0] req_value,
   input  wire logic        [fqvr_pkg::PosWidth-1:0]   req_position,
   output logic                                      rsp_valid,
   output logic             [fqvr_pkg::StatWidth-1:0]  rsp_status,
   output logic signed      [fqvr_pkg::ValueWidth-1:0] rsp_read_value,
   output logic             [fqvr_pkg::CountWidth-1:0] rsp_removed_count,
   output logic             [fqvr_pkg::CountWidth-1:0] rsp_entry_count,
   output logic signed      [fqvr_pkg::ValueWidth-1:0] rsp_front_value,
   output logic signed      [fqvr_pkg::ValueWidth-1:0] rsp_rear_value
);

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int CmpW = (CntW > fqvr_pkg::PosWidth) ? CntW : fqvr_pkg::PosWidth;
   localparam int VW   = fqvr_pkg::ValueWidth;
   localparam int OW   = fqvr_pkg::CountWidth;

   function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] head,
                                               input logic [CntW-1:0] offset);
      logic [CntW:0] sum;
      sum = (CntW + 1)'(head) + (CntW + 1)'(offset);
      if (sum >= (CntW + 1)'(DEPTH)) begin
         sum = sum - (CntW + 1)'(DEPTH);
      end
      return IdxW'(sum);
   endfunction

   fqvr_pkg::state_type state_ff, state_in;

   logic [IdxW-1:0] head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [VW-1:0]   front_ff, front_in;
   logic [VW-1:0]   rear_ff, rear_in;
   logic [VW-1:0]   value_ff, value_in;
   logic [CntW-1:0] scan_rd_ff, scan_rd_in;
   logic [CntW-1:0] scan_left_ff, scan_left_in;
   logic [CntW-1:0] kept_ff, kept_in;
   logic [CntW-1:0] removed_ff, removed_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fqvr_pkg::StatWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [VW-1:0]                 rsp_read_ff, rsp_read_in;
   logic [OW-1:0]                 rsp_removed_ff, rsp_removed_in;
   logic [OW-1:0]                 rsp_count_ff, rsp_count_in;
   logic [VW-1:0]                 rsp_front_ff, rsp_front_in;
   logic [VW-1:0]                 rsp_rear_ff, rsp_rear_in;

   logic            accept;
   logic            read_ok;
   logic [CmpW-1:0] pos_ext;
   logic [CntW-1:0] pos_offset;

   logic            ram_we;
   logic [IdxW-1:0] ram_wr_addr;
   logic [VW-1:0]   ram_wr_data;
   logic [IdxW-1:0] ram_rd_addr;
   logic [VW-1:0]   ram_rd_data;

   fqvr_ram #(
      .Width(VW),
      .Depth(DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign busy       = (state_ff != fqvr_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign pos_ext    = CmpW'(req_position);
   assign read_ok    = (pos_ext != '0) && (pos_ext <= CmpW'(count_ff));
   assign pos_offset = CntW'(pos_ext - CmpW'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fqvr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == fqvr_pkg::REQ_POP && count_ff > CntW'(1)) begin
                  state_in = fqvr_pkg::ST_POP_WAIT;
               end else if (req_type == fqvr_pkg::REQ_READ && read_ok) begin
                  state_in = fqvr_pkg::ST_READ_WAIT;
               end else if (req_type == fqvr_pkg::REQ_REMOVE && count_ff != '0) begin
                  state_in = fqvr_pkg::ST_SCAN;
               end
            end
         end
         fqvr_pkg::ST_POP_WAIT:  state_in = fqvr_pkg::ST_IDLE;
         fqvr_pkg::ST_READ_WAIT: state_in = fqvr_pkg::ST_IDLE;
         fqvr_pkg::ST_SCAN: begin
            if (scan_left_ff == CntW'(1)) begin
               state_in = fqvr_pkg::ST_IDLE;
            end
         end
         default: state_in = fqvr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      front_in       = front_ff;
      rear_in        = rear_ff;
      value_in       = value_ff;
      scan_rd_in     = scan_rd_ff;
      scan_left_in   = scan_left_ff;
      kept_in        = kept_ff;
      removed_in     = removed_ff;
      ram_we         = 1'b0;
      ram_wr_addr    = slot_of(head_ff, kept_ff);
      ram_wr_data    = ram_rd_data;
      ram_rd_addr    = slot_of(head_ff, scan_rd_ff);
      rsp_valid_in   = 1'b0;
      rsp_status_in  = fqvr_pkg::STAT_OK;
      rsp_read_in    = '0;
      rsp_removed_in = '0;

      unique case (state_ff)
         fqvr_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  fqvr_pkg::REQ_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CntW'(DEPTH)) begin
                        rsp_status_in = fqvr_pkg::STAT_FULL;
                     end else begin
                        ram_we      = 1'b1;
                        ram_wr_addr = slot_of(head_ff, count_ff);
                        ram_wr_data = req_value;
                        count_in    = count_ff + CntW'(1);
                        rear_in     = req_value;
                        if (count_ff == '0) begin
                           front_in = req_value;
                        end
                     end
                  end
                  fqvr_pkg::REQ_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fqvr_pkg::STAT_EMPTY;
                     end else begin
                        head_in     = slot_of(head_ff, CntW'(1));
                        count_in    = count_ff - CntW'(1);
                        ram_rd_addr = slot_of(head_ff, CntW'(1));
                        if (count_ff == CntW'(1)) begin
                           rsp_valid_in   = 1'b1;
                           rsp_removed_in = OW'(1);
                        end
                     end
                  end
                  fqvr_pkg::REQ_READ: begin
                     if (read_ok) begin
                        ram_rd_addr = slot_of(head_ff, pos_offset);
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fqvr_pkg::STAT_BADPOS;
                     end
                  end
                  fqvr_pkg::REQ_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_rd_addr  = slot_of(head_ff, '0);
                        value_in     = req_value;
                        scan_rd_in   = CntW'(1);
                        scan_left_in = count_ff;
                        kept_in      = '0;
                        removed_in   = '0;
                     end
                  end
                  fqvr_pkg::REQ_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                     head_in      = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         fqvr_pkg::ST_POP_WAIT: begin
            front_in       = ram_rd_data;
            rsp_valid_in   = 1'b1;
            rsp_removed_in = OW'(1);
         end
         fqvr_pkg::ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_read_in  = ram_rd_data;
         end
         fqvr_pkg::ST_SCAN: begin
            if (scan_rd_ff < count_ff) begin
               scan_rd_in = scan_rd_ff + CntW'(1);
            end
            if (ram_rd_data == value_ff) begin
               removed_in = removed_ff + CntW'(1);
            end else begin
               ram_we  = 1'b1;
               kept_in = kept_ff + CntW'(1);
               rear_in = ram_rd_data;
               if (kept_ff == '0) begin
                  front_in = ram_rd_data;
               end
            end
            scan_left_in = scan_left_ff - CntW'(1);
            if (scan_left_ff == CntW'(1)) begin
               count_in       = kept_in;
               rsp_valid_in   = 1'b1;
               rsp_removed_in = OW'(removed_in);
            end
         end
         default: begin
         end
      endcase

      rsp_count_in = OW'(count_in);
      if (count_in == '0) begin
         rsp_front_in = '0;
         rsp_rear_in  = '0;
      end else begin
         rsp_front_in = front_in;
         rsp_rear_in  = rear_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fqvr_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff       <= front_in;
      rear_ff        <= rear_in;
      value_ff       <= value_in;
      scan_rd_ff     <= scan_rd_in;
      scan_left_ff   <= scan_left_in;
      kept_ff        <= kept_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_rear_ff    <= rsp_rear_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_value    = rsp_read_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_front_value   = rsp_front_ff;
   assign rsp_rear_value    = rsp_rear_ff;

endmodule

`default_nettype wire

FILE: rtl/core/fqvr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fqvr_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
